### hdl/rrst_pkg.sv
// shared constants and types of the range add / range sum tree
package rrst_pkg;
    localparam int MAX_POSITIONS = 65536;
    localparam int NODE_COUNT    = 4 * MAX_POSITIONS;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int IDX_W         = 17;
    localparam int DATA_W        = 64;
    localparam int STACK_DEPTH   = 32;
    localparam int STACK_W       = $clog2(STACK_DEPTH);
    localparam int SP_W          = STACK_W + 1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STG_LEFT  = 2'd0;
    localparam logic [1:0] STG_RIGHT = 2'd1;
    localparam logic [1:0] STG_FOLD  = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] pend;
    } t_entry;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [1:0]        stage;
    } t_frame;
endpackage

### hdl/rrst_req_if.sv
// request channel of the range add / range sum tree
interface rrst_req_if;
    import rrst_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [IDX_W-1:0]         left_index;
    logic [IDX_W-1:0]         right_index;
    logic signed [DATA_W-1:0] delta_value;
    modport source (output valid, op, left_index, right_index, delta_value, input ready);
    modport sink   (input valid, op, left_index, right_index, delta_value, output ready);
endinterface

### hdl/rrst_rsp_if.sv
// response channel of the range add / range sum tree
interface rrst_rsp_if;
    import rrst_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_sum;
    logic                     range_error;
    modport source (output valid, range_sum, range_error, input ready);
    modport sink   (input valid, range_sum, range_error, output ready);
endinterface

### hdl/rrst_ram.sv
// generic simple dual port ram with registered read
module rrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

### hdl/range_add_range_sum_tree.sv
// range add / range sum segment tree with lazy pending adds in one node ram
//
// channel   dir   signals
// i_req     in    valid ready op left_index right_index delta_value
// o_rsp     out   valid ready range_sum range_error
// i_cfg     in    i_cfg_we i_cfg_wdata (size_in_use)
//
// one request at a time; the node work is serialised by the single ram read and write
// ports and the shared 32 by 17 multiplier, and a pending add is pushed down to both
// children of a partly covered node before the walk goes below it
// a bad range is answered without a walk
// after reset and after each size write a clearing pass writes every node ram entry, i_req held off
// the response register holds a result while the next request is already taken
module range_add_range_sum_tree (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rrst_pkg::IDX_W-1:0] i_cfg_wdata,
    rrst_req_if.sink                   i_req,
    rrst_rsp_if.source                 o_rsp
);
    import rrst_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_EVAL  = 15'b000000000000100,
        S_QACC  = 15'b000000000001000,
        S_PD    = 15'b000000000010000,
        S_PDR   = 15'b000000000100000,
        S_PUSHL = 15'b000000001000000,
        S_S2A   = 15'b000000010000000,
        S_S2B   = 15'b000000100000000,
        S_G_M0  = 15'b000001000000000,
        S_G_M1  = 15'b000010000000000,
        S_G_RD  = 15'b000100000000000,
        S_G_WR  = 15'b001000000000000,
        S_POP   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0]  r_size, n_size;
    logic              r_out_valid, n_out_valid;

    logic              r_op, n_op, r_err, n_err, r_out_err, n_out_err;
    logic [IDX_W-1:0]  r_l, n_l, r_r, n_r, r_g_len, n_g_len;
    logic [DATA_W-1:0] r_delta, n_delta, r_acc, n_acc, r_tmp, n_tmp, r_p, n_p;
    logic [DATA_W-1:0] r_g_amt, n_g_amt, r_prod, n_prod, r_out_sum, n_out_sum;
    logic [31:0]       r_hi, n_hi;
    logic [NODE_W-1:0] r_g_node, n_g_node;

    t_frame r_stk [STACK_DEPTH];
    t_frame top, push_frame;
    logic   push_en, upd_en;
    logic [1:0] upd_stage;
    logic [STACK_W-1:0] top_idx, push_idx;

    logic              ram_we, ram_re;
    logic [NODE_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;

    logic [IDX_W:0]    mid_w;
    logic [IDX_W-1:0]  mid;
    logic [NODE_W-1:0] left_node, right_node;
    logic              covered;
    logic [31:0]       mul_a;
    logic [48:0]       mul_out;
    logic [IDX_W-1:0]  cfg_sat;

    rrst_ram #(.WIDTH($bits(t_entry)), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign top_idx    = STACK_W'(r_sp - SP_W'(1));
    assign push_idx   = r_sp[STACK_W-1:0];
    assign top        = r_stk[top_idx];
    assign mid_w      = {1'b0, top.lo} + {1'b0, top.hi};
    assign mid        = mid_w[IDX_W:1];
    assign left_node  = {top.node[NODE_W-2:0], 1'b0};
    assign right_node = {top.node[NODE_W-2:0], 1'b1};
    assign covered    = (r_l <= top.lo) && (top.hi <= r_r);
    assign mul_out    = {17'b0, mul_a} * {32'b0, r_g_len};

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_sat = IDX_W'(1);
        end else if (32'(i_cfg_wdata) > MAX_POSITIONS) begin
            cfg_sat = IDX_W'(MAX_POSITIONS);
        end else begin
            cfg_sat = i_cfg_wdata;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.range_sum   = r_out_sum;
    assign o_rsp.range_error = r_out_err;

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_sp = r_sp;       n_clr = r_clr;
        n_size = r_size;     n_op = r_op;       n_err = r_err;     n_l = r_l;
        n_r = r_r;           n_delta = r_delta; n_acc = r_acc;     n_tmp = r_tmp;
        n_p = r_p;           n_g_amt = r_g_amt; n_g_len = r_g_len; n_g_node = r_g_node;
        n_prod = r_prod;     n_hi = r_hi;
        n_out_sum = r_out_sum;
        n_out_err = r_out_err;
        n_out_valid = r_out_valid && !o_rsp.ready;
        push_en = 1'b0;  push_frame = '0;
        upd_en = 1'b0;   upd_stage = STG_LEFT;
        ram_we = 1'b0;   ram_waddr = top.node;  ram_wdata = '0;
        ram_re = 1'b0;   ram_raddr = top.node;
        mul_a = r_g_amt[31:0];

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_l     = i_req.left_index;
                    n_r     = i_req.right_index;
                    n_delta = i_req.delta_value;
                    n_acc   = '0;
                    if (i_req.left_index == '0 || i_req.left_index > i_req.right_index
                        || i_req.right_index > r_size) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_err      = 1'b0;
                        push_en    = 1'b1;
                        push_frame = '{node: NODE_W'(1), lo: IDX_W'(1), hi: r_size,
                                       stage: STG_LEFT};
                        n_sp       = r_sp + SP_W'(1);
                        n_state    = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                case (top.stage)
                    STG_LEFT: begin
                        if (covered && r_op == OP_ADD) begin
                            n_g_node = top.node;
                            n_g_len  = top.hi - top.lo + IDX_W'(1);
                            n_g_amt  = r_delta;
                            n_ret    = S_POP;
                            n_state  = S_G_M0;
                        end else if (covered) begin
                            ram_re  = 1'b1;
                            n_state = S_QACC;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_PD;
                        end
                    end
                    STG_RIGHT: begin
                        upd_en    = 1'b1;
                        upd_stage = STG_FOLD;
                        if (r_r > mid) begin
                            push_en    = 1'b1;
                            push_frame = '{node: right_node, lo: mid + IDX_W'(1),
                                           hi: top.hi, stage: STG_LEFT};
                            n_sp       = r_sp + SP_W'(1);
                        end
                    end
                    default: begin
                        if (r_op == OP_ADD) begin
                            ram_re    = 1'b1;
                            ram_raddr = left_node;
                            n_state   = S_S2A;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                endcase
            end
            S_QACC: begin
                n_acc   = r_acc + ram_rdata.sum;
                n_state = S_POP;
            end
            S_PD: begin
                if (ram_rdata.pend == '0) begin
                    n_state = S_PUSHL;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sum: ram_rdata.sum, pend: '0};
                    n_p       = ram_rdata.pend;
                    n_g_amt   = ram_rdata.pend;
                    n_g_node  = left_node;
                    n_g_len   = mid - top.lo + IDX_W'(1);
                    n_ret     = S_PDR;
                    n_state   = S_G_M0;
                end
            end
            S_PDR: begin
                n_g_amt  = r_p;
                n_g_node = right_node;
                n_g_len  = top.hi - mid;
                n_ret    = S_PUSHL;
                n_state  = S_G_M0;
            end
            S_PUSHL: begin
                upd_en    = 1'b1;
                upd_stage = STG_RIGHT;
                if (r_l <= mid) begin
                    push_en    = 1'b1;
                    push_frame = '{node: left_node, lo: top.lo, hi: mid, stage: STG_LEFT};
                    n_sp       = r_sp + SP_W'(1);
                end
                n_state = S_EVAL;
            end
            S_S2A: begin
                n_tmp     = ram_rdata.sum;
                ram_re    = 1'b1;
                ram_raddr = right_node;
                n_state   = S_S2B;
            end
            S_S2B: begin
                ram_we    = 1'b1;
                ram_wdata = '{sum: r_tmp + ram_rdata.sum, pend: '0};
                n_state   = S_POP;
            end
            S_G_M0: begin
                mul_a   = r_g_amt[31:0];
                n_prod  = DATA_W'(mul_out);
                n_state = S_G_M1;
            end
            S_G_M1: begin
                mul_a   = r_g_amt[63:32];
                n_hi    = mul_out[31:0];
                n_state = S_G_RD;
            end
            S_G_RD: begin
                n_prod    = r_prod + {r_hi, 32'b0};
                ram_re    = 1'b1;
                ram_raddr = r_g_node;
                n_state   = S_G_WR;
            end
            S_G_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_g_node;
                ram_wdata = '{sum: ram_rdata.sum + r_prod, pend: ram_rdata.pend + r_g_amt};
                n_state   = r_ret;
            end
            S_POP: begin
                n_sp    = r_sp - SP_W'(1);
                n_state = (r_sp == SP_W'(1)) ? S_DONE : S_EVAL;
            end
            S_DONE: begin
                if (r_err || r_op == OP_QUERY) begin
                    if (!r_out_valid || o_rsp.ready) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = r_err ? '0 : r_acc;
                        n_out_err   = r_err;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_size  = cfg_sat;
            n_clr   = '0;
            n_sp    = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_POP;
            r_sp        <= '0;
            r_clr       <= '0;
            r_size      <= IDX_W'(MAX_POSITIONS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_sp        <= n_sp;
            r_clr       <= n_clr;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;      r_err    <= n_err;    r_l      <= n_l;
        r_r       <= n_r;       r_delta  <= n_delta;  r_acc    <= n_acc;
        r_tmp     <= n_tmp;     r_p      <= n_p;      r_g_amt  <= n_g_amt;
        r_g_len   <= n_g_len;   r_g_node <= n_g_node; r_prod   <= n_prod;
        r_hi      <= n_hi;      r_out_sum <= n_out_sum;
        r_out_err <= n_out_err;
        if (upd_en) begin
            r_stk[top_idx].stage <= upd_stage;
        end
        if (push_en) begin
            r_stk[push_idx] <= push_frame;
        end
    end

    // walk bookkeeping
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("walk stack overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_sp == '0))
        else $error("walk stack not empty when idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("node ram written outside a walk");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("response loaded outside done");
endmodule
